@@ sv/acrt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, types and helpers for the associative cache replacement tracker.
// Used by the line store, the shared compare unit and the top level.

package acrt_pkg;

  localparam int unsigned LINES      = 16;
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned LINE_W      = $clog2(LINES);
  localparam int unsigned CNT_W       = $clog2(LINES + 1);
  localparam int unsigned BLOCK_W     = ADDR_BITS;
  localparam int unsigned LFSR_W      = 16;
  localparam int unsigned LFSR_CNT_W  = $clog2(LFSR_W);
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned OUT_LINE_W  = 4;
  localparam int unsigned OUT_BLOCK_W = 32;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned CMP_W       = (BLOCK_W > COUNT_BITS) ? BLOCK_W : COUNT_BITS;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    POL_RANDOM,
    POL_FIFO,
    POL_LRU,
    POL_LFU
  } policy_e;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_GT,
    CMP_LT,
    CMP_GE
  } cmp_op_e;

  typedef struct packed {
    cmp_op_e          op;
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic             flag;
    logic [CMP_W-1:0] diff;
  } cmp_res_t;

  // One step of the right-shifting Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

@@ sv/acrt_line_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Block-number store, one entry per cache line: one write port, one registered read port.
// Depends on acrt_pkg for widths.

module acrt_line_ram import acrt_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [LINE_W-1:0]  waddr_i,
  input  logic [BLOCK_W-1:0] wdata_i,
  input  logic [LINE_W-1:0]  raddr_i,
  output logic [BLOCK_W-1:0] rdata_o
);

  logic [BLOCK_W-1:0] mem [LINES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/acrt_cmp_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared compare / subtract unit used by the scan, remainder and victim-scan steps of the sequencer.
// Depends on acrt_pkg for the request and result types.

module acrt_cmp_unit import acrt_pkg::*; (
  input  cmp_req_t req_i,
  output cmp_res_t res_o
);

  logic [CMP_W:0] sub;
  logic           lt;
  logic           eq;

  assign sub = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign lt  = sub[CMP_W];
  assign eq  = (req_i.a == req_i.b);

  always_comb begin
    res_o.diff = sub[CMP_W-1:0];
    unique case (req_i.op)
      CMP_EQ: res_o.flag = eq;
      CMP_GT: res_o.flag = !lt && !eq;
      CMP_LT: res_o.flag = lt;
      CMP_GE: res_o.flag = !lt;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/assoc_cache_replacement_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Fully associative cache replacement tracker: top level with the sequencer and line state.
// Depends on acrt_pkg, acrt_line_ram and acrt_cmp_unit.
//
// Give one byte address per item on address_i with start; it is taken when busy is
// low. The result appears for exactly one cycle with done_o high and cannot be held off,
// so capture it in that cycle. A single comparator serves the block scan, the victim
// scan and the random remainder in turn: first a scan of the filled lines for the block
// (one line per cycle, through the registered store read), then, on a miss with every
// line in use, the victim choice: FIFO takes the line at its pointer, LRU and LFU scan the
// lines in use once more, and random takes a 16-step bit-serial remainder of the LFSR
// value by the line count; busy falls in the cycle that shows done_o, and a new item may
// be taken in that same cycle. Configuration writes must go through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while the block is idle; the block does not enforce this. Writing the
// seed also reloads the LFSR (a zero seed loads one).

module assoc_cache_replacement_tracker import acrt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [ADDR_BITS-1:0]   address_i,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  output logic                   done_o,
  output logic                   hit_o,
  output logic [OUT_LINE_W-1:0]  line_o,
  output logic                   evicted_o,
  output logic [OUT_BLOCK_W-1:0] evicted_block_o,
  output logic [TOTAL_W-1:0]     hit_total_o,
  output logic [TOTAL_W-1:0]     access_total_o
);

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_OFFSET = 2'd1;
  localparam logic [1:0] CFG_LINES  = 2'd2;
  localparam logic [1:0] CFG_SEED   = 2'd3;

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MISS   = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_VSCAN  = 3'd4;
  localparam logic [2:0] S_VREAD  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam logic [LINE_W-1:0] RANK_OLDEST = LINE_W'(LINES - 1);

  // Configuration
  policy_e          policy_q, policy_d;
  logic [4:0]       offset_q, offset_d;
  logic [4:0]       lines_q,  lines_d;

  // Control and line state
  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      n_q, n_d;
  logic [CNT_W-1:0]      valid_q, valid_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [LINE_W-1:0]     rd_idx_q, rd_idx_d;
  logic                  hit_q, hit_d;
  logic                  fill_q, fill_d;
  logic                  ev_q, ev_d;
  logic [LINE_W-1:0]     line_q, line_d;
  logic [LINE_W-1:0]     best_q, best_d;
  logic [LFSR_CNT_W-1:0] bit_q, bit_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      filled_q, filled_d;
  logic [LINE_W-1:0]     fifo_q, fifo_d;
  logic [LFSR_W-1:0]     lfsr_q, lfsr_d;
  logic [TOTAL_W-1:0]    hits_q, hits_d;
  logic [TOTAL_W-1:0]    acc_q, acc_d;
  logic [LINE_W-1:0]     rank_q [LINES];
  logic [LINE_W-1:0]     rank_d [LINES];
  logic [COUNT_BITS-1:0] use_q  [LINES];
  logic [COUNT_BITS-1:0] use_d  [LINES];

  // Payload
  logic [BLOCK_W-1:0]    block_q, block_d;
  logic [BLOCK_W-1:0]    evb_q, evb_d;
  logic [LFSR_W-1:0]     div_q, div_d;
  logic [LINE_W-1:0]     rem_q, rem_d;
  logic [COUNT_BITS-1:0] best_val_q, best_val_d;

  // Shared datapath
  cmp_req_t           cmp_req;
  cmp_res_t           cmp_res;
  logic [BLOCK_W-1:0] rd_data;
  logic [LINE_W-1:0]  ram_raddr;
  logic               ram_we;
  logic [LINE_W-1:0]  sel_idx;
  logic [LINE_W-1:0]  rank_rd;
  logic [COUNT_BITS-1:0] use_rd;
  logic [COUNT_BITS-1:0] cur_val;
  logic [CNT_W-1:0]   n_eff;
  logic [LINE_W:0]    rem_shift;

  acrt_line_ram u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (line_q),
    .wdata_i (block_q),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  acrt_cmp_unit u_cmp (
    .req_i (cmp_req),
    .res_o (cmp_res)
  );

  assign ram_raddr = (state_q == S_SCAN) ? idx_q[LINE_W-1:0] : line_q;
  assign ram_we    = (state_q == S_FINISH) && !hit_q;

  // Single read port into the per-line counters: scan index while choosing a victim,
  // otherwise the line being updated.
  assign sel_idx = (state_q == S_VSCAN) ? idx_q[LINE_W-1:0] : line_q;
  assign rank_rd = rank_q[sel_idx];
  assign use_rd  = use_q[sel_idx];
  assign cur_val = (policy_q == POL_LRU) ? COUNT_BITS'(rank_rd) : use_rd;

  // Clamp the configured line count to 1..LINES
  always_comb begin
    if (lines_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(lines_q) > LINES) begin
      n_eff = CNT_W'(LINES);
    end else begin
      n_eff = CNT_W'(lines_q);
    end
  end

  assign rem_shift = {rem_q, div_q[LFSR_W-1]};

  // Operand selection for the shared compare unit
  always_comb begin
    cmp_req.op = CMP_EQ;
    cmp_req.a  = '0;
    cmp_req.b  = '0;
    unique case (state_q)
      S_SCAN: begin
        cmp_req.op = CMP_EQ;
        cmp_req.a  = CMP_W'(rd_data);
        cmp_req.b  = CMP_W'(block_q);
      end
      S_MOD: begin
        cmp_req.op = CMP_GE;
        cmp_req.a  = CMP_W'(rem_shift);
        cmp_req.b  = CMP_W'(n_q);
      end
      S_VSCAN: begin
        cmp_req.op = (policy_q == POL_LRU) ? CMP_GT : CMP_LT;
        cmp_req.a  = CMP_W'(cur_val);
        cmp_req.b  = CMP_W'(best_val_q);
      end
      default: begin
        cmp_req.op = CMP_EQ;
      end
    endcase
  end

  always_comb begin
    logic [CNT_W-1:0]  fifo_ptr;
    logic [CNT_W-1:0]  fifo_inc;
    logic [CNT_W-1:0]  lim;
    logic [LINE_W-1:0] old_rank;

    policy_d   = policy_q;
    offset_d   = offset_q;
    lines_d    = lines_q;
    state_d    = state_q;
    n_d        = n_q;
    valid_d    = valid_q;
    idx_d      = idx_q;
    rd_vld_d   = rd_vld_q;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    fill_d     = fill_q;
    ev_d       = ev_q;
    line_d     = line_q;
    best_d     = best_q;
    bit_d      = bit_q;
    done_d     = 1'b0;
    filled_d   = filled_q;
    fifo_d     = fifo_q;
    lfsr_d     = lfsr_q;
    hits_d     = hits_q;
    acc_d      = acc_q;
    rank_d     = rank_q;
    use_d      = use_q;
    block_d    = block_q;
    evb_d      = evb_q;
    div_d      = div_q;
    rem_d      = rem_q;
    best_val_d = best_val_q;
    fifo_ptr   = '0;
    fifo_inc   = '0;
    lim        = '0;
    old_rank   = '0;

    // Configuration writes must arrive only while idle; the block does not enforce this
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POLICY: policy_d = policy_e'(cfg_wdata_i[1:0]);
        CFG_OFFSET: offset_d = cfg_wdata_i[4:0];
        CFG_LINES:  lines_d  = cfg_wdata_i[4:0];
        CFG_SEED:   lfsr_d   = (cfg_wdata_i == '0) ? LFSR_W'(1) : LFSR_W'(cfg_wdata_i);
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          block_d  = BLOCK_W'(address_i >> offset_q);
          n_d      = n_eff;
          valid_d  = (filled_q < n_eff) ? filled_q : n_eff;
          idx_d    = '0;
          rd_vld_d = 1'b0;
          hit_d    = 1'b0;
          fill_d   = 1'b0;
          ev_d     = 1'b0;
          state_d  = S_SCAN;
        end
      end

      // Issue one store read per cycle and compare the one issued the cycle before
      S_SCAN: begin
        if (rd_vld_q && cmp_res.flag) begin
          hit_d    = 1'b1;
          line_d   = rd_idx_q;
          rd_vld_d = 1'b0;
          state_d  = S_FINISH;
        end else if (idx_q < valid_q) begin
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q[LINE_W-1:0];
          idx_d    = idx_q + CNT_W'(1);
        end else begin
          rd_vld_d = 1'b0;
          state_d  = S_MISS;
        end
      end

      S_MISS: begin
        if (filled_q < n_q) begin
          fill_d  = 1'b1;
          line_d  = filled_q[LINE_W-1:0];
          state_d = S_FINISH;
        end else begin
          ev_d = 1'b1;
          unique case (policy_q)
            POL_RANDOM: begin
              lfsr_d  = lfsr_step(lfsr_q);
              div_d   = lfsr_step(lfsr_q);
              rem_d   = '0;
              bit_d   = '0;
              state_d = S_MOD;
            end
            POL_FIFO: begin
              fifo_ptr = (CNT_W'(fifo_q) >= n_q) ? '0 : CNT_W'(fifo_q);
              fifo_inc = fifo_ptr + CNT_W'(1);
              line_d   = fifo_ptr[LINE_W-1:0];
              fifo_d   = (fifo_inc >= n_q) ? '0 : fifo_inc[LINE_W-1:0];
              state_d  = S_VREAD;
            end
            POL_LRU: begin
              best_d     = '0;
              best_val_d = COUNT_BITS'(rank_q[0]);
              idx_d      = CNT_W'(1);
              state_d    = S_VSCAN;
            end
            POL_LFU: begin
              best_d     = '0;
              best_val_d = use_q[0];
              idx_d      = CNT_W'(1);
              state_d    = S_VSCAN;
            end
          endcase
        end
      end

      // Restoring remainder of the LFSR value by the line count, one bit a cycle
      S_MOD: begin
        rem_d = cmp_res.flag ? cmp_res.diff[LINE_W-1:0] : rem_shift[LINE_W-1:0];
        div_d = div_q << 1;
        bit_d = bit_q + LFSR_CNT_W'(1);
        if (bit_q == LFSR_CNT_W'(LFSR_W - 1)) begin
          line_d  = rem_d;
          state_d = S_VREAD;
        end
      end

      // Walk the lines in use, keeping the oldest (LRU) or least used (LFU)
      S_VSCAN: begin
        if (idx_q < n_q) begin
          if (cmp_res.flag) begin
            best_d     = idx_q[LINE_W-1:0];
            best_val_d = cur_val;
          end
          idx_d = idx_q + CNT_W'(1);
        end else begin
          line_d  = best_q;
          state_d = S_VREAD;
        end
      end

      // Fetch the block about to be replaced
      S_VREAD: begin
        state_d = S_FINISH;
      end

      S_FINISH: begin
        done_d  = 1'b1;
        evb_d   = ev_q ? rd_data : '0;
        state_d = S_IDLE;

        if (hit_q) begin
          lim = valid_q;
        end else if (fill_q) begin
          lim = filled_q + CNT_W'(1);
        end else begin
          lim = n_q;
        end
        old_rank = fill_q ? RANK_OLDEST : rank_rd;

        // Age every younger line, then make this one most recent
        for (int i = 0; i < LINES; i++) begin
          if (LINE_W'(i) == line_q) begin
            rank_d[i] = '0;
            if (hit_q) begin
              use_d[i] = (use_q[i] == '1) ? use_q[i] : use_q[i] + COUNT_BITS'(1);
            end else begin
              use_d[i] = COUNT_BITS'(1);
            end
          end else if (CNT_W'(i) < lim && rank_q[i] < old_rank &&
                       rank_q[i] < RANK_OLDEST) begin
            rank_d[i] = rank_q[i] + LINE_W'(1);
          end
        end

        if (hit_q) begin
          hits_d = (hits_q == '1) ? hits_q : hits_q + TOTAL_W'(1);
        end
        if (fill_q) begin
          filled_d = filled_q + CNT_W'(1);
        end
        acc_d = (acc_q == '1) ? acc_q : acc_q + TOTAL_W'(1);
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_RANDOM;
      offset_q <= 5'd2;
      lines_q  <= 5'd16;
      state_q  <= S_IDLE;
      n_q      <= '0;
      valid_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      hit_q    <= 1'b0;
      fill_q   <= 1'b0;
      ev_q     <= 1'b0;
      line_q   <= '0;
      best_q   <= '0;
      bit_q    <= '0;
      done_q   <= 1'b0;
      filled_q <= '0;
      fifo_q   <= '0;
      lfsr_q   <= LFSR_W'(1);
      hits_q   <= '0;
      acc_q    <= '0;
      for (int i = 0; i < LINES; i++) begin
        rank_q[i] <= '0;
        use_q[i]  <= '0;
      end
    end else begin
      policy_q <= policy_d;
      offset_q <= offset_d;
      lines_q  <= lines_d;
      state_q  <= state_d;
      n_q      <= n_d;
      valid_q  <= valid_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      rd_idx_q <= rd_idx_d;
      hit_q    <= hit_d;
      fill_q   <= fill_d;
      ev_q     <= ev_d;
      line_q   <= line_d;
      best_q   <= best_d;
      bit_q    <= bit_d;
      done_q   <= done_d;
      filled_q <= filled_d;
      fifo_q   <= fifo_d;
      lfsr_q   <= lfsr_d;
      hits_q   <= hits_d;
      acc_q    <= acc_d;
      rank_q   <= rank_d;
      use_q    <= use_d;
    end
  end

  // Datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    block_q    <= block_d;
    evb_q      <= evb_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    best_val_q <= best_val_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign line_o          = OUT_LINE_W'(line_q);
  assign evicted_o       = ev_q;
  assign evicted_block_o = OUT_BLOCK_W'(evb_q);
  assign hit_total_o     = hits_q;
  assign access_total_o  = acc_q;

endmodule

`default_nettype wire
